// ===== rtl/scalc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes of the fixed-point calculator.
// No dependencies; used by every module of the block but scalc_div.
package scalc_pkg;

	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_SUB  = 3'd1;
	localparam logic [2:0] OP_MUL  = 3'd2;
	localparam logic [2:0] OP_DIV  = 3'd3;
	localparam logic [2:0] OP_FACT = 3'd4;
	localparam logic [2:0] OP_POW  = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIV0 = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] WORD_MIN = 32'h8000_0000;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_MRD,
		S_DIV,
		S_FMUL,
		S_FCHK,
		S_PMUL,
		S_PCHK,
		S_FIN
	} state_t;

	typedef struct packed {
		logic signed [63:0] prod;
		logic        [31:0] fx;
		logic               sat;
	} mul_res_t;

endpackage

// ===== rtl/scalar_calculator_alu.sv =====
`timescale 1ns / 1ps
// Top level of the signed fixed-point calculator: sequencer, operand mux, output register.
// Depends on scalc_pkg, scalc_mul and scalc_div.

// Fixed-point calculator. A request transfer carries an operation code and two signed
// operands with FRAC_BITS fraction bits; each request yields exactly one result transfer
// with a status (ok, divide by zero, saturated). The block takes one request at a time:
// req_stall is high from the transfer until the result has been handed to the output
// register, which itself may wait on rsp_stall while the next request is taken. Add,
// subtract and unknown codes go from the execute state straight to the finishing
// state; multiply passes a product read state; divide waits on the restoring divider,
// one quotient bit per cycle; factorial stops once the product passes the integer limit
// (within about a dozen steps); power loops min(floor(b), MAX_EXPONENT) times. Both run
// on the single shared multiplier, a multiply state then a check state per step.
module scalar_calculator_alu #(
	parameter int FRAC_BITS    = 16,
	parameter int MAX_EXPONENT = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [31:0] result_value,
	output logic [1:0]         status
);

	localparam int FW    = 31 - FRAC_BITS;         // integer magnitude bits
	localparam int DIV_W = 32 + FRAC_BITS;         // dividend width after scaling
	localparam int CW    = $clog2(MAX_EXPONENT + 1);
	localparam logic [31:0] ONE   = 32'd1 << FRAC_BITS;
	localparam logic [31:0] LIMIT = scalc_pkg::WORD_MAX >> FRAC_BITS;
	localparam logic [DIV_W-1:0] Q_POS_MAX = DIV_W'(scalc_pkg::WORD_MAX);
	localparam logic [DIV_W-1:0] Q_NEG_MAX = DIV_W'(scalc_pkg::WORD_MIN);

	scalc_pkg::state_t state_q, state_d;

	// Request registers.
	logic [2:0]         op_q;
	logic signed [31:0] a_q, b_q;

	// Loop registers.
	logic [FW-1:0]      f_q, i_q, n_q;
	logic signed [31:0] p_q;
	logic [CW-1:0]      cnt_q;
	logic               sat_q;

	// Pending result and output register.
	logic [31:0] res_q;
	logic [1:0]  st_q;
	logic        rsp_valid_q;
	logic [31:0] rsp_value_q;
	logic [1:0]  rsp_status_q;

	// Shared unit handshakes.
	logic                mul_en;
	logic signed [31:0]  mul_a, mul_b;
	scalc_pkg::mul_res_t mul_res;
	logic                div_start, div_done;
	logic [DIV_W-1:0]    div_quot;

	// Decode helpers.
	logic [32:0]        sum;
	logic               sum_sat;
	logic signed [31:0] n_full, e_full;
	logic               n_small, e_small;
	logic [31:0]        abs_a, abs_b;
	logic               div_neg;
	logic               fact_over, fact_last, pow_last;
	logic               out_load;

	scalc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.res (mul_res)
	);

	scalc_div #(.DW(DIV_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({abs_a, {FRAC_BITS{1'b0}}}),
		.divisor  (abs_b),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Add and subtract in 33 bits; overflow shows as disagreeing top bits.
	assign sum     = (op_q == scalc_pkg::OP_SUB)
	               ? {a_q[31], a_q} - {b_q[31], b_q}
	               : {a_q[31], a_q} + {b_q[31], b_q};
	assign sum_sat = sum[32] != sum[31];

	assign n_full  = a_q >>> FRAC_BITS;
	assign e_full  = b_q >>> FRAC_BITS;
	assign n_small = n_full <= 32'sd1;
	assign e_small = e_full <= 32'sd0;

	assign abs_a   = a_q[31] ? (~a_q) + 32'd1 : a_q;
	assign abs_b   = b_q[31] ? (~b_q) + 32'd1 : b_q;
	assign div_neg = a_q[31] ^ b_q[31];

	assign fact_over = mul_res.prod > $signed({32'd0, LIMIT});
	assign fact_last = i_q == n_q;
	assign pow_last  = cnt_q == CW'(1);

	// The output register takes a result when empty or being drained this edge.
	assign out_load = (state_q == scalc_pkg::S_FIN) && (!rsp_valid_q || !rsp_stall);

	// Operand select for the shared multiplier.
	always_comb begin
		case (op_q)
			scalc_pkg::OP_FACT: begin
				mul_a = {{(32 - FW){1'b0}}, f_q};
				mul_b = {{(32 - FW){1'b0}}, i_q};
			end
			scalc_pkg::OP_POW: begin
				mul_a = p_q;
				mul_b = a_q;
			end
			default: begin
				mul_a = a_q;
				mul_b = b_q;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			scalc_pkg::S_IDLE: begin
				if (req_valid) state_d = scalc_pkg::S_EXEC;
			end
			scalc_pkg::S_EXEC: begin
				case (op_q)
					scalc_pkg::OP_MUL:  state_d = scalc_pkg::S_MRD;
					scalc_pkg::OP_DIV:  state_d = (b_q == '0) ? scalc_pkg::S_FIN
					                                          : scalc_pkg::S_DIV;
					scalc_pkg::OP_FACT: state_d = n_small ? scalc_pkg::S_FIN
					                                      : scalc_pkg::S_FMUL;
					scalc_pkg::OP_POW:  state_d = e_small ? scalc_pkg::S_FIN
					                                      : scalc_pkg::S_PMUL;
					default:            state_d = scalc_pkg::S_FIN;
				endcase
			end
			scalc_pkg::S_MRD: state_d = scalc_pkg::S_FIN;
			scalc_pkg::S_DIV: begin
				if (div_done) state_d = scalc_pkg::S_FIN;
			end
			scalc_pkg::S_FMUL: state_d = scalc_pkg::S_FCHK;
			scalc_pkg::S_FCHK: begin
				state_d = (fact_over || fact_last) ? scalc_pkg::S_FIN : scalc_pkg::S_FMUL;
			end
			scalc_pkg::S_PMUL: state_d = scalc_pkg::S_PCHK;
			scalc_pkg::S_PCHK: begin
				state_d = pow_last ? scalc_pkg::S_FIN : scalc_pkg::S_PMUL;
			end
			scalc_pkg::S_FIN: begin
				if (out_load) state_d = scalc_pkg::S_IDLE;
			end
			default: state_d = scalc_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		req_stall = 1'b1;
		mul_en    = 1'b0;
		div_start = 1'b0;
		case (state_q)
			scalc_pkg::S_IDLE: req_stall = 1'b0;
			scalc_pkg::S_EXEC: begin
				mul_en    = op_q == scalc_pkg::OP_MUL;
				div_start = (op_q == scalc_pkg::OP_DIV) && (b_q != '0);
			end
			scalc_pkg::S_FMUL: mul_en = 1'b1;
			scalc_pkg::S_PMUL: mul_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= scalc_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			scalc_pkg::S_IDLE: begin
				// Hold the request for the whole operation.
				if (req_valid) begin
					op_q <= req_type;
					a_q  <= operand_a;
					b_q  <= operand_b;
				end
			end
			scalc_pkg::S_EXEC: begin
				st_q  <= scalc_pkg::ST_OK;
				sat_q <= 1'b0;
				case (op_q)
					scalc_pkg::OP_ADD, scalc_pkg::OP_SUB: begin
						if (sum_sat) begin
							res_q <= sum[32] ? scalc_pkg::WORD_MIN : scalc_pkg::WORD_MAX;
							st_q  <= scalc_pkg::ST_SAT;
						end else begin
							res_q <= sum[31:0];
						end
					end
					scalc_pkg::OP_DIV: begin
						if (b_q == '0) begin
							res_q <= '0;
							st_q  <= scalc_pkg::ST_DIV0;
						end
					end
					scalc_pkg::OP_FACT: begin
						// Counts of one or less give 1.0; otherwise start from 1 * 2.
						res_q <= ONE;
						f_q   <= FW'(1);
						i_q   <= FW'(2);
						n_q   <= n_full[FW-1:0];
					end
					scalc_pkg::OP_POW: begin
						res_q <= ONE;
						p_q   <= ONE;
						if (e_full > 32'(MAX_EXPONENT)) begin
							cnt_q <= CW'(MAX_EXPONENT);
						end else begin
							cnt_q <= e_full[CW-1:0];
						end
					end
					scalc_pkg::OP_MUL: ;
					default: res_q <= a_q;
				endcase
			end
			scalc_pkg::S_MRD: begin
				res_q <= mul_res.fx;
				st_q  <= mul_res.sat ? scalc_pkg::ST_SAT : scalc_pkg::ST_OK;
			end
			scalc_pkg::S_DIV: begin
				if (div_done) begin
					if (!div_neg && (div_quot > Q_POS_MAX)) begin
						res_q <= scalc_pkg::WORD_MAX;
						st_q  <= scalc_pkg::ST_SAT;
					end else if (div_neg && (div_quot > Q_NEG_MAX)) begin
						res_q <= scalc_pkg::WORD_MIN;
						st_q  <= scalc_pkg::ST_SAT;
					end else if (div_neg) begin
						res_q <= (~div_quot[31:0]) + 32'd1;
					end else begin
						res_q <= div_quot[31:0];
					end
				end
			end
			scalc_pkg::S_FCHK: begin
				if (fact_over) begin
					res_q <= scalc_pkg::WORD_MAX;
					st_q  <= scalc_pkg::ST_SAT;
				end else begin
					// Advance the running product and keep its scaled value as the pending result.
					f_q   <= mul_res.prod[FW-1:0];
					i_q   <= i_q + 1'b1;
					res_q <= {1'b0, mul_res.prod[FW-1:0], {FRAC_BITS{1'b0}}};
				end
			end
			scalc_pkg::S_PCHK: begin
				p_q   <= mul_res.fx;
				sat_q <= sat_q | mul_res.sat;
				cnt_q <= cnt_q - 1'b1;
				res_q <= mul_res.fx;
				st_q  <= (sat_q | mul_res.sat) ? scalc_pkg::ST_SAT : scalc_pkg::ST_OK;
			end
			default: ;
		endcase

		if (out_load) begin
			rsp_value_q  <= res_q;
			rsp_status_q <= st_q;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign result_value = rsp_value_q;
	assign status       = rsp_status_q;

`ifndef ASSERT_OFF
	// A request transfer always starts the sequencer.
	a_req_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == scalc_pkg::S_EXEC))
		else $error("request transfer did not start the sequencer");

	// A fresh result only appears out of the finishing state.
	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == scalc_pkg::S_FIN))
		else $error("result appeared outside the finishing state");

	// Divide by zero always reports a zero result.
	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status == scalc_pkg::ST_DIV0)) |-> (result_value == '0))
		else $error("divide by zero with nonzero result");

	// The divider finishes only while the sequencer waits on it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(div_done) |-> (state_q == scalc_pkg::S_DIV))
		else $error("divider finished outside the divide wait");
`endif

endmodule

// ===== rtl/scalc_mul.sv =====
`timescale 1ns / 1ps
// Shared 32x32 signed multiplier with registered product, floor shift and saturation.
// Depends on scalc_pkg for the result struct and saturation limits.
module scalc_mul #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [31:0]  a,
	input  logic signed [31:0]  b,
	output scalc_pkg::mul_res_t res
);

	logic signed [63:0] prod_q;
	logic signed [63:0] shifted;
	logic        [32:0] hi;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	// Arithmetic shift floors toward minus infinity.
	assign shifted = prod_q >>> FRAC_BITS;
	assign hi      = shifted[63:31];

	always_comb begin
		res.prod = prod_q;
		res.sat  = !((&hi) || (~|hi));
		if (res.sat) begin
			res.fx = shifted[63] ? scalc_pkg::WORD_MIN : scalc_pkg::WORD_MAX;
		end else begin
			res.fx = shifted[31:0];
		end
	end

endmodule

// ===== rtl/scalc_div.sv =====
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// No package dependencies.
module scalc_div #(
	parameter int DW = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [31:0]   divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW-1:0] qd_q;
	logic [31:0]   rem_q;
	logic [31:0]   div_q;
	logic [32:0]   rem_sh;
	logic [33:0]   diff;
	logic          ge;

	// The remainder stays below the divisor, so 32 bits hold it.
	assign rem_sh = {rem_q, qd_q[DW-1]};
	assign diff   = {1'b0, rem_sh} - {2'b0, div_q};
	assign ge     = !diff[33];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(DW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qd_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[31:0] : rem_sh[31:0];
			qd_q  <= {qd_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = qd_q;

endmodule

// ===== verif/scalc_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the fixed-point calculator: watches both channels and predicts each result.
// Depends on scalc_pkg; instantiated beside the block by tb_scalar_calculator_alu.
module scalc_checker #(
	parameter int FRAC_BITS    = 16,
	parameter int MAX_EXPONENT = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  logic signed [31:0] result_value,
	input  logic [1:0]         status,
	output int                 mismatch_count,
	output int                 results_outstanding
);

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  code;
	} calc_result_t;

	calc_result_t awaited_results[$];

	initial begin
		mismatch_count      = 0;
		results_outstanding = 0;
	end

	function automatic longint clamp_word(input longint v, inout bit hit);
		if (v > longint'(signed'(scalc_pkg::WORD_MAX))) begin
			hit = 1'b1;
			return longint'(signed'(scalc_pkg::WORD_MAX));
		end
		if (v < longint'(signed'(scalc_pkg::WORD_MIN))) begin
			hit = 1'b1;
			return longint'(signed'(scalc_pkg::WORD_MIN));
		end
		return v;
	endfunction

	// Full product, floor shift, then clamp.
	function automatic longint fx_product(input longint x, input longint y, inout bit hit);
		return clamp_word((x * y) >>> FRAC_BITS, hit);
	endfunction

	function automatic calc_result_t compute_result(input logic [2:0] op,
			input logic signed [31:0] opa, input logic signed [31:0] opb);
		longint a;
		longint b;
		longint one;
		longint r;
		longint n;
		longint f;
		longint e;
		longint i;
		bit hit;
		calc_result_t res;
		a   = opa;
		b   = opb;
		one = longint'(1) <<< FRAC_BITS;
		hit = 1'b0;
		r   = 0;
		res.code = scalc_pkg::ST_OK;
		case (op)
			scalc_pkg::OP_ADD: r = clamp_word(a + b, hit);
			scalc_pkg::OP_SUB: r = clamp_word(a - b, hit);
			scalc_pkg::OP_MUL: r = fx_product(a, b, hit);
			scalc_pkg::OP_DIV: begin
				if (b == 0) begin
					r = 0;
					res.code = scalc_pkg::ST_DIV0;
				end else begin
					r = clamp_word((a * one) / b, hit);
				end
			end
			scalc_pkg::OP_FACT: begin
				n = a >>> FRAC_BITS;
				f = 1;
				for (i = 2; i <= n; i++) begin
					f = f * i;
					if (f > (longint'(signed'(scalc_pkg::WORD_MAX)) >>> FRAC_BITS)) begin
						hit = 1'b1;
						break;
					end
				end
				r = hit ? longint'(signed'(scalc_pkg::WORD_MAX)) : f * one;
			end
			scalc_pkg::OP_POW: begin
				e = b >>> FRAC_BITS;
				if (e > MAX_EXPONENT)
					e = MAX_EXPONENT;
				r = one;
				for (i = 0; i < e; i++)
					r = fx_product(r, a, hit);
			end
			default: r = a;
		endcase
		if (hit && res.code == scalc_pkg::ST_OK)
			res.code = scalc_pkg::ST_SAT;
		res.value = r[31:0];
		return res;
	endfunction

	always @(posedge clk) begin
		calc_result_t exp_res;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_results.size() == 0) begin
					$error("result transfer with no request outstanding: value %0d, status %0d",
						result_value, status);
					mismatch_count++;
				end else begin
					exp_res = awaited_results.pop_front();
					if (result_value !== exp_res.value) begin
						$error("result_value: expected %0d, got %0d",
							$signed(exp_res.value), result_value);
						mismatch_count++;
					end
					if (status !== exp_res.code) begin
						$error("status: expected %0d, got %0d", exp_res.code, status);
						mismatch_count++;
					end
				end
			end
			if (req_valid && !req_stall)
				awaited_results.push_back(compute_result(req_type, operand_a, operand_b));
			results_outstanding = awaited_results.size();
		end
	end

endmodule

// ===== verif/tb_scalar_calculator_alu.sv =====
`timescale 1ns / 1ps
// Testbench top for scalar_calculator_alu: clock, reset, request and result-side traffic, verdict.
// Depends on scalc_pkg, the block's RTL and scalc_checker.
module tb_scalar_calculator_alu;

	localparam int FRAC_BITS    = 16;
	localparam int MAX_EXPONENT = 255;

	// Codes the block does not define; they must echo operand_a.
	localparam logic [2:0] OP_RSV6 = 3'd6;
	localparam logic [2:0] OP_RSV7 = 3'd7;

	localparam logic signed [31:0] FX_ONE = 32'sd1 <<< FRAC_BITS;
	localparam logic [31:0]        FRAC_MASK = (32'd1 << FRAC_BITS) - 32'd1;

	localparam int RANDOM_ITEMS = 1200;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 600;   // longer than the slowest power request
	localparam int CYCLE_LIMIT  = 3000000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [2:0]         req_type = scalc_pkg::OP_ADD;
	logic signed [31:0] operand_a = '0;
	logic signed [31:0] operand_b = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic signed [31:0] result_value;
	logic [1:0]         status;

	int mismatch_count;
	int results_outstanding;
	int cycle_count = 0;

	// Shared between the request side and the result side.
	bit no_idle = 1'b0;       // suppress gaps and stalls on both sides
	bit hold_request = 1'b0;  // ask the result side for one long hold-off

	always #10 clk = ~clk;

	scalar_calculator_alu #(
		.FRAC_BITS   (FRAC_BITS),
		.MAX_EXPONENT(MAX_EXPONENT)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.result_value(result_value),
		.status      (status)
	);

	scalc_checker #(
		.FRAC_BITS   (FRAC_BITS),
		.MAX_EXPONENT(MAX_EXPONENT)
	) u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.req_valid          (req_valid),
		.req_stall          (req_stall),
		.req_type           (req_type),
		.operand_a          (operand_a),
		.operand_b          (operand_b),
		.rsp_valid          (rsp_valid),
		.rsp_stall          (rsp_stall),
		.result_value       (result_value),
		.status             (status),
		.mismatch_count     (mismatch_count),
		.results_outstanding(results_outstanding)
	);

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** scalar_calculator_alu: FAILED **");
			$finish;
		end
	end

	// Mostly short idle runs, now and then a long one.
	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Signed integer part in [lo, hi] with a random fraction below it.
	function automatic logic [31:0] fx_near(input int lo, input int hi);
		int ipart;
		ipart = int'($urandom_range(0, hi - lo)) + lo;
		return (ipart <<< FRAC_BITS) | ($urandom() & FRAC_MASK);
	endfunction

	// General operand: extremes, full-range noise, or small values.
	function automatic logic [31:0] any_word();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 6))
					0: return scalc_pkg::WORD_MAX;
					1: return scalc_pkg::WORD_MIN;
					2: return 32'd0;
					3: return 32'd1;
					4: return 32'hFFFF_FFFF;
					5: return FX_ONE;
					default: return -FX_ONE;
				endcase
			end
			1, 2, 3, 4: return $urandom();
			default: return fx_near(-8, 8);
		endcase
	endfunction

	// Result side: random stall runs, plus one long hold-off on request.
	initial begin
		int run_left;
		bit run_stall;
		run_left  = 0;
		run_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_stall <= 1'b1;
				// count the hold-off here so the request side keeps offering meanwhile
				repeat (LONG_HOLD - 1) @(negedge clk);
				run_left = 0;
			end else begin
				if (run_left == 0) begin
					run_stall = ($urandom_range(0, 2) == 0);
					run_left  = idle_len() + 1;
				end
				run_left--;
				rsp_stall <= run_stall && !no_idle;
			end
		end
	end

	// Present one request and hold it until the block takes the transfer.
	task automatic send_req(input logic [2:0] op, input logic signed [31:0] a,
			input logic signed [31:0] b);
		@(negedge clk);
		req_valid <= 1'b1;
		req_type  <= op;
		operand_a <= a;
		operand_b <= b;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	// Drop valid and wait for every outstanding result.
	task automatic drain_results();
		@(negedge clk);
		req_valid <= 1'b0;
		wait (results_outstanding == 0);
	endtask

	task automatic idle_gap();
		int gap;
		gap = no_idle ? 0 : idle_len();
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_random_req();
		logic [2:0]  op;
		logic [31:0] a;
		logic [31:0] b;
		case ($urandom_range(0, 15))
			0, 1:    op = scalc_pkg::OP_ADD;
			2, 3:    op = scalc_pkg::OP_SUB;
			4, 5:    op = scalc_pkg::OP_MUL;
			6, 7, 8: op = scalc_pkg::OP_DIV;
			9, 10:   op = scalc_pkg::OP_FACT;
			11, 12, 13: op = scalc_pkg::OP_POW;
			14:      op = OP_RSV6;
			default: op = OP_RSV7;
		endcase
		a = any_word();
		b = any_word();
		case (op)
			scalc_pkg::OP_DIV: begin
				if ($urandom_range(0, 9) == 0)
					b = 32'd0;
			end
			scalc_pkg::OP_FACT: begin
				if ($urandom_range(0, 9) < 7)
					a = fx_near(-2, 12);
			end
			scalc_pkg::OP_POW: begin
				// bases near one keep long chains away from saturation
				if ($urandom_range(0, 9) < 7)
					a = fx_near(-2, 1);
				// exponents mostly small; full-range values reach the clamp
				if ($urandom_range(0, 19) < 17)
					b = fx_near(-2, 24);
			end
			default: ;
		endcase
		send_req(op, a, b);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed: saturation at both ends, floor rounding, divide by zero,
		// factorial and power count edges, exponent clamp, undefined codes.
		send_req(scalc_pkg::OP_ADD, scalc_pkg::WORD_MAX, FX_ONE);
		send_req(scalc_pkg::OP_ADD, scalc_pkg::WORD_MIN, -FX_ONE);
		send_req(scalc_pkg::OP_ADD, 32'sd0, 32'sd0);
		send_req(scalc_pkg::OP_SUB, scalc_pkg::WORD_MIN, FX_ONE);
		send_req(scalc_pkg::OP_SUB, scalc_pkg::WORD_MAX, scalc_pkg::WORD_MIN);
		send_req(scalc_pkg::OP_MUL, scalc_pkg::WORD_MAX, scalc_pkg::WORD_MAX);
		send_req(scalc_pkg::OP_MUL, scalc_pkg::WORD_MIN, scalc_pkg::WORD_MIN);
		// tiny negative product floors to -1 lsb
		send_req(scalc_pkg::OP_MUL, -32'sd1, 32'sd1);
		send_req(scalc_pkg::OP_DIV, 5 * FX_ONE, 32'sd0);
		send_req(scalc_pkg::OP_DIV, scalc_pkg::WORD_MIN, -FX_ONE);
		// quotient truncates toward zero
		send_req(scalc_pkg::OP_DIV, -FX_ONE, 3 * FX_ONE);
		send_req(scalc_pkg::OP_DIV, scalc_pkg::WORD_MAX, 32'sd1);
		send_req(scalc_pkg::OP_FACT, 32'sd0, scalc_pkg::WORD_MAX);
		send_req(scalc_pkg::OP_FACT, -3 * FX_ONE, 32'sd0);
		send_req(scalc_pkg::OP_FACT, 8 * FX_ONE - 1, 32'sd0); // floor gives seven
		send_req(scalc_pkg::OP_FACT, 8 * FX_ONE, 32'sd0);
		send_req(scalc_pkg::OP_FACT, scalc_pkg::WORD_MAX, scalc_pkg::WORD_MIN);
		send_req(scalc_pkg::OP_POW, 2 * FX_ONE, 32'sd0);
		send_req(scalc_pkg::OP_POW, 2 * FX_ONE, -FX_ONE);
		send_req(scalc_pkg::OP_POW, 2 * FX_ONE, 14 * FX_ONE);
		send_req(scalc_pkg::OP_POW, 2 * FX_ONE, 15 * FX_ONE + FX_ONE / 2);
		// clamps to the exponent limit
		send_req(scalc_pkg::OP_POW, FX_ONE, scalc_pkg::WORD_MAX);
		send_req(scalc_pkg::OP_POW, -FX_ONE / 2, 3 * FX_ONE);
		send_req(OP_RSV6, scalc_pkg::WORD_MIN, scalc_pkg::WORD_MAX);
		send_req(OP_RSV7, 32'sh1234_5678, 32'sd0);
		drain_results();

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			no_idle = (k >= 150 && k < 300) || (k >= 900 && k < 1000);
			if (k == 400)
				hold_request = 1'b1;
			if (k == 800)
				drain_results();
			idle_gap();
			send_random_req();
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && results_outstanding == 0)
			$display("** scalar_calculator_alu: PASSED **");
		else
			$display("** scalar_calculator_alu: FAILED **");
		$finish;
	end

endmodule
